@@ rtl/swpec_pkg.sv @@
package swpec_pkg;

    localparam int unsigned WINDOW_BITS = 32;
    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 32'd60;

    localparam logic [0:0] REG_WINDOW = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

endpackage

@@ rtl/sliding_window_peak_event_count.sv @@
// Sliding-window peak event counter.
//
// Input channel (s_valid/s_ready, s_timestamp): one event timestamp in seconds
// per transaction, in log order. Result channel (m_valid/m_ready): one result
// per input transaction with the window count, the peak count since reset, the
// item indices of the best window and the overflow flag.
// Configuration: APB register 0 at byte address 0 holds window_seconds.
//
// Each accepted transaction first drops the expired entries from the window
// FIFO, then, once the output register is free, pushes the event and loads
// the result there, raising m_valid; only then is a new input accepted. The
// FIFO memory has one registered read port, and one drop is tested per cycle
// through a single subtract-and-compare unit. Every event pushes once.
//
// Reset clears the FIFO occupancy, the item counters and the peak record and
// sets window_seconds to 60; no memory clearing is needed.
// A result is held in the output register until taken; a new input is accepted
// while it waits, and the block stalls only when a second result is ready.
module sliding_window_peak_event_count #(
    parameter int unsigned FIFO_DEPTH = 256,
    parameter int unsigned TIME_BITS  = 40,
    parameter int unsigned INDEX_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [swpec_pkg::WINDOW_BITS-1:0]   pwdata,
    output logic [swpec_pkg::WINDOW_BITS-1:0]   prdata,
    output logic                                pready,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [TIME_BITS-1:0]                s_timestamp,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]     m_window_count,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]     m_peak_count,
    output logic [INDEX_BITS-1:0]               m_peak_begin_index,
    output logic [INDEX_BITS-1:0]               m_peak_end_index,
    output logic                                m_overflow
);

    import swpec_pkg::*;

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned CMP_W = (TIME_BITS > WINDOW_BITS) ? TIME_BITS : WINDOW_BITS;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    state_t state_reg, state_next;

    logic [WINDOW_BITS-1:0] window_reg;
    logic [TIME_BITS-1:0]   ts_reg;
    logic [PTR_W-1:0]       oldest_ptr_reg, oldest_ptr_next;
    logic [PTR_W-1:0]       tail_ptr_reg, tail_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [INDEX_BITS-1:0]  oldest_index_reg, oldest_index_next;
    logic [INDEX_BITS-1:0]  next_index_reg, next_index_next;
    logic [CNT_W-1:0]       best_count_reg, best_count_next;
    logic [INDEX_BITS-1:0]  best_begin_reg, best_begin_next;
    logic [INDEX_BITS-1:0]  best_end_reg, best_end_next;

    logic                   m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]       m_window_count_reg;
    logic [CNT_W-1:0]       m_peak_count_reg;
    logic [INDEX_BITS-1:0]  m_peak_begin_reg;
    logic [INDEX_BITS-1:0]  m_peak_end_reg;
    logic                   m_overflow_reg;

    logic [TIME_BITS-1:0]   oldest_ts;
    logic [TIME_BITS:0]     span;
    logic                   expired;
    logic                   forced;
    logic                   out_free;
    logic                   finish;
    logic                   drop;
    logic                   cfg_write;
    logic [CNT_W-1:0]       fill_count;
    logic [PTR_W-1:0]       oldest_ptr_inc;
    logic [PTR_W-1:0]       tail_ptr_inc;

    swpec_store #(
        .DEPTH (FIFO_DEPTH),
        .WIDTH (TIME_BITS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (finish),
        .wr_addr (tail_ptr_reg),
        .wr_data (ts_reg),
        .rd_addr (oldest_ptr_next),
        .rd_data (oldest_ts)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_WINDOW);

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_WINDOW) begin
            prdata = window_reg;
        end
    end

    assign span    = {1'b0, ts_reg} - {1'b0, oldest_ts};
    assign expired = !span[TIME_BITS]
                     && (CMP_W'(span[TIME_BITS-1:0]) > CMP_W'(window_reg));

    assign out_free = !m_valid_reg || m_ready;
    assign drop     = (state_reg == ST_SCAN) && (count_reg != '0) && expired;
    assign finish   = (state_reg == ST_SCAN) && !((count_reg != '0) && expired) && out_free;
    assign forced   = (count_reg == CNT_FULL);

    assign oldest_ptr_inc = (oldest_ptr_reg == PTR_LAST) ? '0 : oldest_ptr_reg + 1'b1;
    assign tail_ptr_inc   = (tail_ptr_reg == PTR_LAST) ? '0 : tail_ptr_reg + 1'b1;
    assign fill_count     = forced ? count_reg : count_reg + 1'b1;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next        = state_reg;
        oldest_ptr_next   = oldest_ptr_reg;
        tail_ptr_next     = tail_ptr_reg;
        count_next        = count_reg;
        oldest_index_next = oldest_index_reg;
        next_index_next   = next_index_reg;
        best_count_next   = best_count_reg;
        best_begin_next   = best_begin_reg;
        best_end_next     = best_end_reg;
        m_valid_next      = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (drop) begin
                    oldest_ptr_next   = oldest_ptr_inc;
                    count_next        = count_reg - 1'b1;
                    oldest_index_next = oldest_index_reg + 1'b1;
                end else if (finish) begin
                    if (forced) begin
                        oldest_ptr_next   = oldest_ptr_inc;
                        oldest_index_next = oldest_index_reg + 1'b1;
                    end
                    tail_ptr_next   = tail_ptr_inc;
                    count_next      = fill_count;
                    next_index_next = next_index_reg + 1'b1;
                    if (fill_count > best_count_reg) begin
                        best_count_next = fill_count;
                        best_begin_next = oldest_index_next;
                        best_end_next   = next_index_reg;
                    end
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            window_reg       <= WINDOW_RESET;
            oldest_ptr_reg   <= '0;
            tail_ptr_reg     <= '0;
            count_reg        <= '0;
            oldest_index_reg <= '0;
            next_index_reg   <= '0;
            best_count_reg   <= '0;
            best_begin_reg   <= '0;
            best_end_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            oldest_ptr_reg   <= oldest_ptr_next;
            tail_ptr_reg     <= tail_ptr_next;
            count_reg        <= count_next;
            oldest_index_reg <= oldest_index_next;
            next_index_reg   <= next_index_next;
            best_count_reg   <= best_count_next;
            best_begin_reg   <= best_begin_next;
            best_end_reg     <= best_end_next;
            m_valid_reg      <= m_valid_next;
            if (cfg_write) begin
                window_reg <= pwdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ts_reg <= s_timestamp;
        end
        if (finish) begin
            m_window_count_reg <= count_next;
            m_peak_count_reg   <= best_count_next;
            m_peak_begin_reg   <= best_begin_next;
            m_peak_end_reg     <= best_end_next;
            m_overflow_reg     <= forced;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_window_count     = m_window_count_reg;
    assign m_peak_count       = m_peak_count_reg;
    assign m_peak_begin_index = m_peak_begin_reg;
    assign m_peak_end_index   = m_peak_end_reg;
    assign m_overflow         = m_overflow_reg;

endmodule

@@ rtl/swpec_store.sv @@
module swpec_store #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned WIDTH = 40
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/swpec_checker.sv @@
module swpec_checker #(
    parameter int unsigned CNT_W = 9
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [CNT_W-1:0] m_window_count,
    input logic [CNT_W-1:0] m_peak_count
);

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_window_count) && $stable(m_peak_count))
        else $error("result changed while stalled");

    a_peak_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_peak_count >= m_window_count))
        else $error("peak count below window count");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_window_count != '0))
        else $error("empty window reported");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on back-to-back cycles");

endmodule

bind sliding_window_peak_event_count swpec_checker #(
    .CNT_W ($clog2(FIFO_DEPTH + 1))
) u_swpec_checker (.*);

@@ sim/tb_top.sv @@
module tb_top;

    import swpec_pkg::*;

    localparam int unsigned DEPTH      = 256;
    localparam int unsigned TS_W       = 40;
    localparam int unsigned IDX_W      = 32;
    localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
    localparam int unsigned STALL_MAX  = 5000;
    localparam int unsigned DRAIN_TAIL = DEPTH + 4;

    typedef enum logic [0:0] {
        ROW_EVENT,
        ROW_WINDOW
    } row_kind_t;

    typedef struct packed {
        logic [CNT_W-1:0] win_cnt;
        logic [CNT_W-1:0] peak_cnt;
        logic [IDX_W-1:0] peak_first;
        logic [IDX_W-1:0] peak_final;
        logic             ovf;
    } peak_report_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [TS_W-1:0]        ts;
        logic [WINDOW_BITS-1:0] span;
        logic                   typed;
        peak_report_t           want;
    } stim_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [2:0]             paddr;
    logic [WINDOW_BITS-1:0] pwdata;
    logic [WINDOW_BITS-1:0] prdata;
    logic                   pready;
    logic                   s_valid;
    logic                   s_ready;
    logic [TS_W-1:0]        s_timestamp;
    logic                   m_valid;
    logic                   m_ready;
    logic [CNT_W-1:0]       m_window_count;
    logic [CNT_W-1:0]       m_peak_count;
    logic [IDX_W-1:0]       m_peak_begin_index;
    logic [IDX_W-1:0]       m_peak_end_index;
    logic                   m_overflow;

    // window tracker state
    logic [TS_W-1:0]        held_ts [DEPTH];
    logic [7:0]             head;
    logic [CNT_W-1:0]       fill;
    logic [IDX_W-1:0]       head_idx;
    logic [IDX_W-1:0]       next_idx;
    logic [CNT_W-1:0]       top_cnt;
    logic [IDX_W-1:0]       top_first;
    logic [IDX_W-1:0]       top_last;
    logic [WINDOW_BITS-1:0] span_limit;

    peak_report_t           reports_due [$];
    stim_row_t              plan [17];
    int unsigned            faults;
    int unsigned            idle_run;
    bit                     quiet;
    logic [WINDOW_BITS-1:0] span_pick;

    sliding_window_peak_event_count #(
        .FIFO_DEPTH (DEPTH),
        .TIME_BITS  (TS_W),
        .INDEX_BITS (IDX_W)
    ) uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_timestamp        (s_timestamp),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_window_count     (m_window_count),
        .m_peak_count       (m_peak_count),
        .m_peak_begin_index (m_peak_begin_index),
        .m_peak_end_index   (m_peak_end_index),
        .m_overflow         (m_overflow)
    );

    always #6 aclk = ~aclk;

    function automatic stim_row_t ev(input logic [TS_W-1:0] ts);
        stim_row_t r;
        r      = '0;
        r.kind = ROW_EVENT;
        r.ts   = ts;
        return r;
    endfunction

    function automatic stim_row_t ev_chk(input logic [TS_W-1:0] ts, input int wc, input int pc,
                                         input logic [IDX_W-1:0] lo_idx,
                                         input logic [IDX_W-1:0] hi_idx, input logic ovf);
        stim_row_t r;
        r                 = ev(ts);
        r.typed           = 1'b1;
        r.want.win_cnt    = CNT_W'(wc);
        r.want.peak_cnt   = CNT_W'(pc);
        r.want.peak_first = lo_idx;
        r.want.peak_final = hi_idx;
        r.want.ovf        = ovf;
        return r;
    endfunction

    function automatic stim_row_t set_win(input logic [WINDOW_BITS-1:0] val);
        stim_row_t r;
        r      = '0;
        r.kind = ROW_WINDOW;
        r.span = val;
        return r;
    endfunction

    task automatic note_fault(input string msg);
        if (faults < 10) begin
            $display("%s", msg);
        end
        faults++;
    endtask

    task automatic retire_oldest();
        head     = head + 8'd1;
        fill     = fill - 1'b1;
        head_idx = head_idx + 1'b1;
    endtask

    task automatic track_event(input logic [TS_W-1:0] ts, output peak_report_t rep);
        logic [7:0] slot;
        logic       forced;
        forced = 1'b0;
        while (fill != 0 && ts > held_ts[head] && (ts - held_ts[head]) > TS_W'(span_limit)) begin
            retire_oldest();
        end
        if (fill == CNT_W'(DEPTH)) begin
            retire_oldest();
            forced = 1'b1;
        end
        slot          = head + fill[7:0];
        held_ts[slot] = ts;
        fill          = fill + 1'b1;
        if (fill > top_cnt) begin
            top_cnt   = fill;
            top_first = head_idx;
            top_last  = next_idx;
        end
        next_idx       = next_idx + 1'b1;
        rep.win_cnt    = fill;
        rep.peak_cnt   = top_cnt;
        rep.peak_first = top_first;
        rep.peak_final = top_last;
        rep.ovf        = forced;
    endtask

    task automatic offer_event(input logic [TS_W-1:0] ts, input logic typed,
                               input peak_report_t want);
        peak_report_t model;
        while (!quiet && $urandom_range(99) < 18) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_timestamp <= ts;
        do @(posedge aclk); while (!s_ready);
        track_event(ts, model);
        reports_due.push_back(typed ? want : model);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_window(input logic [WINDOW_BITS-1:0] val);
        settle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_WINDOW, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        span_limit = val;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== val) begin
            note_fault($sformatf("window readback mismatch: expected %h got %h", val, prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(input logic [WINDOW_BITS-1:0] span, input int unsigned items,
                             input int unsigned max_step, input bit messy, input bit calm);
        logic [63:0]     wide;
        logic [TS_W-1:0] seq_ts;
        logic [TS_W-1:0] ts;
        int unsigned     pick;
        write_window(span);
        quiet  = calm;
        wide   = {$urandom, $urandom};
        seq_ts = {1'b0, wide[TS_W-2:0]};
        for (int unsigned n = 0; n < items; n++) begin
            pick = $urandom_range(99);
            wide = {$urandom, $urandom};
            if (messy && pick < 8) begin
                ts = wide[TS_W-1:0];
            end else if (messy && pick < 13) begin
                ts = seq_ts - TS_W'($urandom_range(max_step + 1, 1));
            end else begin
                if (messy && pick < 17) begin
                    seq_ts = seq_ts + TS_W'(span) + 1 + TS_W'($urandom_range(max_step));
                end else if ($urandom_range(3) != 0) begin
                    seq_ts = seq_ts + TS_W'($urandom_range(max_step));
                end
                ts = seq_ts;
            end
            offer_event(ts, 1'b0, '0);
        end
    endtask

    always @(posedge aclk) begin
        peak_report_t got;
        peak_report_t want;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            idle_run <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got.win_cnt    = m_window_count;
                got.peak_cnt   = m_peak_count;
                got.peak_first = m_peak_begin_index;
                got.peak_final = m_peak_end_index;
                got.ovf        = m_overflow;
                if (reports_due.size() == 0) begin
                    note_fault($sformatf("result with no pending transaction: cnt=%0d peak=%0d",
                                         got.win_cnt, got.peak_cnt));
                end else begin
                    want = reports_due.pop_front();
                    if (got !== want) begin
                        note_fault($sformatf({"mismatch: expected cnt=%0d peak=%0d first=%0d ",
                                              "last=%0d ovf=%0b, got cnt=%0d peak=%0d ",
                                              "first=%0d last=%0d ovf=%0b"},
                                             want.win_cnt, want.peak_cnt, want.peak_first,
                                             want.peak_final, want.ovf, got.win_cnt,
                                             got.peak_cnt, got.peak_first, got.peak_final,
                                             got.ovf));
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_run <= 0;
            end else if (idle_run >= STALL_MAX) begin
                $display("*** FAILED ***");
                $finish;
            end else begin
                idle_run <= idle_run + 1;
            end
            m_ready <= quiet || ($urandom_range(99) >= 18);
        end
    end

    initial begin
        aclk        = 1'b0;
        aresetn     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_valid     = 1'b0;
        s_timestamp = '0;
        quiet       = 1'b0;
        faults      = 0;
        head        = '0;
        fill        = '0;
        head_idx    = '0;
        next_idx    = '0;
        top_cnt     = '0;
        top_first   = '0;
        top_last    = '0;
        span_limit  = WINDOW_RESET;

        plan = '{
            ev_chk(40'd0,              1, 1, 0, 0, 1'b0),
            ev_chk(40'd60,             2, 2, 0, 1, 1'b0),
            ev_chk(40'd121,            1, 2, 0, 1, 1'b0),
            ev_chk(40'd100,            2, 2, 0, 1, 1'b0),
            ev_chk(40'hFF_FFFF_FFFF,   1, 2, 0, 1, 1'b0),
            ev_chk(40'd0,              2, 2, 0, 1, 1'b0),
            set_win(32'd0),
            ev_chk(40'd0,              3, 3, 4, 6, 1'b0),
            ev(40'hFF_FFFF_FFFF),
            ev(40'd1),
            set_win(32'hFFFF_FFFF),
            ev(40'h00_FFFF_FFFF),
            ev(40'h55_5555_5555),
            ev(40'hAA_AAAA_AAAA),
            set_win(32'd1),
            ev(40'hAA_AAAA_AAAA),
            ev(40'hAA_AAAA_AAAB)
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WINDOW) begin
                write_window(plan[i].span);
            end else begin
                offer_event(plan[i].ts, plan[i].typed, plan[i].want);
            end
        end

        run_phase(32'hFFFF_FFFF, 300, 1000, 1'b0, 1'b0);
        run_phase(WINDOW_BITS'($urandom_range(200, 1)), 100, 40, 1'b1, 1'b0);
        run_phase('0, 80, 2, 1'b1, 1'b1);
        span_pick = $urandom;
        run_phase(span_pick, 80, (span_pick >> 3) + 1, 1'b1, 1'b0);
        run_phase(WINDOW_RESET, 90, 30, 1'b1, 1'b0);

        s_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);

        if (faults == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
